### design/mst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

    localparam int TIME_W     = 48;
    localparam int PERIOD_W   = 26;
    localparam int CMD_W      = 5;
    localparam int STEP_W     = 5;
    localparam int MOTOR_W    = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;
    localparam int LEVEL_IN_W = 6;

    localparam int MOTOR_SLOTS        = 12;
    localparam int STEP_COUNT_DEFAULT = 19;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_US = PERIOD_W'(100000);
    localparam logic [CMD_W-1:0]    CMD_BASE      = CMD_W'(2);
    localparam logic [CMD_W-1:0]    CMD_MAX       = CMD_W'(31);

    localparam logic [MODE_W-1:0] MODE_TIMED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_NUMBER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT  = 2'd3;

    localparam logic [MODE_W-1:0]   RST_TEST_MODE    = 2'd0;
    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD  = PERIOD_W'(1000000);
    localparam logic [MOTOR_W-1:0]  RST_MOTOR_NUMBER = 4'd1;
    localparam logic [MOTOR_W-1:0]  RST_MOTOR_COUNT  = 4'd4;

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        logic              manual_nav_mode;
        logic              armed;
        logic              rc_valid;
        logic              aux1_on;
        logic              aux2_on;
        logic              lockdown;
    } t_in_item;

    typedef struct packed {
        logic [CMD_W-1:0]   step_command;
        logic               override_active;
        logic               force_stop;
        logic               all_zero_latched;
        logic [MOTOR_W-1:0] motor_index;
        logic               running;
    } t_out_item;

    // Command level for step k, saturating at the largest code.
    function automatic logic [CMD_W-1:0] level_of(input logic [LEVEL_IN_W-1:0] k);
        logic [LEVEL_IN_W:0] sum;
        sum = (LEVEL_IN_W+1)'(CMD_BASE) + (LEVEL_IN_W+1)'(k);
        if (sum > (LEVEL_IN_W+1)'(CMD_MAX)) begin
            return CMD_MAX;
        end
        return sum[CMD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/motor_step_test_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall  o_out_data (t_out_item)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// An accepted transaction passes S_LOAD, which starts the repeated-subtraction
// step divider, then waits in S_CALC for the divider and a free output slot.
// A new transaction is accepted only while the sequencer is idle.
// Synchronous active-low reset clears the sequencer state, configuration and output valid flag;
// the r_in and r_out data registers are not reset. A result waits in the output register while
// the output is stalled; the next transaction may be accepted meanwhile but is not finished until it is taken.

module motor_step_test_sequencer
    import mst_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QUOT_W = $clog2(STEP_COUNT + 1);
    localparam logic [QUOT_W-1:0] QUOT_LIMIT = QUOT_W'(STEP_COUNT);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(STEP_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CALC
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0]   r_test_mode, n_test_mode;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [MOTOR_W-1:0]  r_motor_number, n_motor_number;
    logic [MOTOR_W-1:0]  r_motor_count, n_motor_count;

    logic              r_seq_running, n_seq_running;
    logic [TIME_W-1:0] r_start, n_start;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_prev_aux2, n_prev_aux2;
    logic              r_prev_known, n_prev_known;
    logic              r_completed, n_completed;
    logic [CMD_W-1:0]  r_cmd, n_cmd;

    t_in_item  r_in, n_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic                div_start;
    logic                div_busy;
    logic [QUOT_W-1:0]   div_quot;
    logic [PERIOD_W-1:0] period_sat;
    logic [TIME_W-1:0]   eff_start;
    logic [TIME_W-1:0]   elapsed;

    logic              motor_mode, aux_active, gate, slot_free;
    logic [MOTOR_W-1:0] test_motor;
    logic [MOTOR_W-1:0] count_eff;
    logic              u_seq_running, u_prev_aux2, u_prev_known, u_completed;
    logic [TIME_W-1:0] u_start;
    logic [STEP_W-1:0] u_step;
    logic [CMD_W-1:0]  u_cmd;
    t_out_item         u_out;

    mst_step_div #(
        .STEP_COUNT (STEP_COUNT),
        .QUOT_W     (QUOT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (elapsed),
        .i_divisor  (period_sat),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign period_sat = (r_period < MIN_PERIOD_US) ? MIN_PERIOD_US : r_period;
    assign eff_start  = (r_start == '0) ? r_in.time_us : r_start;
    assign elapsed    = r_in.time_us - eff_start;

    // Sequencer update for the held transaction.
    always_comb begin
        motor_mode = (r_test_mode == MODE_TIMED) || (r_test_mode == MODE_EDGE);
        aux_active = r_in.rc_valid && r_in.aux1_on;
        gate       = r_in.manual_nav_mode && aux_active && r_in.armed && motor_mode
                     && !r_in.lockdown;
        test_motor = (r_motor_number != '0) ? r_motor_number - MOTOR_W'(1) : '0;
        count_eff  = ({1'b0, r_motor_count} > (MOTOR_W+1)'(MOTOR_SLOTS)) ? '0
                     : r_motor_count;

        u_seq_running = r_seq_running;
        u_start       = r_start;
        u_step        = r_step;
        u_prev_aux2   = r_prev_aux2;
        u_prev_known  = r_prev_known;
        u_completed   = r_completed;
        u_cmd         = r_cmd;

        if (!gate || r_completed) begin
            u_cmd = '0;
        end else if (!r_seq_running) begin
            u_seq_running = 1'b1;
            u_start       = r_in.time_us;
            u_cmd         = CMD_BASE;
            u_step        = '0;
            if (r_test_mode == MODE_EDGE) begin
                u_prev_aux2  = r_in.aux2_on;
                u_prev_known = 1'b1;
            end
        end else if (r_test_mode == MODE_TIMED) begin
            u_start = eff_start;
            if (div_quot != QUOT_LIMIT) begin
                u_cmd = level_of(LEVEL_IN_W'(div_quot));
            end else begin
                u_completed   = 1'b1;
                u_seq_running = 1'b0;
                u_start       = '0;
                u_cmd         = '0;
            end
        end else begin
            if (r_prev_known && !r_prev_aux2 && r_in.aux2_on && (r_step < LAST_STEP)) begin
                u_step = r_step + STEP_W'(1);
            end
            u_prev_aux2  = r_in.aux2_on;
            u_prev_known = 1'b1;
            u_cmd        = level_of(LEVEL_IN_W'(u_step));
            if (u_step == LAST_STEP) begin
                u_completed   = 1'b1;
                u_seq_running = 1'b0;
                u_start       = '0;
                u_cmd         = '0;
            end
        end

        u_out.step_command     = u_cmd;
        u_out.running          = gate && u_seq_running;
        u_out.override_active  = gate && u_seq_running && (test_motor < count_eff);
        u_out.force_stop       = r_in.manual_nav_mode && motor_mode && aux_active
                                 && (r_in.lockdown || !r_in.armed);
        u_out.all_zero_latched = u_completed && motor_mode;
        u_out.motor_index      = test_motor;
    end

    always_comb begin
        n_state        = r_state;
        n_test_mode    = r_test_mode;
        n_period       = r_period;
        n_motor_number = r_motor_number;
        n_motor_count  = r_motor_count;
        n_seq_running  = r_seq_running;
        n_start        = r_start;
        n_step         = r_step;
        n_prev_aux2    = r_prev_aux2;
        n_prev_known   = r_prev_known;
        n_completed    = r_completed;
        n_cmd          = r_cmd;
        n_in           = r_in;
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        div_start      = 1'b0;
        slot_free      = !r_out_valid || !i_out_stall;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEST_MODE:    n_test_mode    = i_cfg_data[MODE_W-1:0];
                CFG_STEP_PERIOD:  n_period       = i_cfg_data[PERIOD_W-1:0];
                CFG_MOTOR_NUMBER: n_motor_number = i_cfg_data[MOTOR_W-1:0];
                CFG_MOTOR_COUNT:  n_motor_count  = i_cfg_data[MOTOR_W-1:0];
                default:          n_test_mode    = r_test_mode;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                div_start = 1'b1;
                n_state   = S_CALC;
            end
            S_CALC: begin
                if (!div_busy && slot_free) begin
                    n_seq_running = u_seq_running;
                    n_start       = u_start;
                    n_step        = u_step;
                    n_prev_aux2   = u_prev_aux2;
                    n_prev_known  = u_prev_known;
                    n_completed   = u_completed;
                    n_cmd         = u_cmd;
                    n_out         = u_out;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_test_mode    <= RST_TEST_MODE;
            r_period       <= RST_STEP_PERIOD;
            r_motor_number <= RST_MOTOR_NUMBER;
            r_motor_count  <= RST_MOTOR_COUNT;
            r_seq_running  <= 1'b0;
            r_start        <= '0;
            r_step         <= '0;
            r_prev_aux2    <= 1'b0;
            r_prev_known   <= 1'b0;
            r_completed    <= 1'b0;
            r_cmd          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_test_mode    <= n_test_mode;
            r_period       <= n_period;
            r_motor_number <= n_motor_number;
            r_motor_count  <= n_motor_count;
            r_seq_running  <= n_seq_running;
            r_start        <= n_start;
            r_step         <= n_step;
            r_prev_aux2    <= n_prev_aux2;
            r_prev_known   <= n_prev_known;
            r_completed    <= n_completed;
            r_cmd          <= n_cmd;
            r_out_valid    <= n_out_valid;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_latched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.all_zero_latched) |-> (o_out_data.step_command == '0))
        else $error("latched result carries a nonzero command");

    a_override_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.override_active) |-> o_out_data.running)
        else $error("override without a running sequence");

    a_running_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.running) |-> (o_out_data.step_command >= CMD_BASE))
        else $error("running sequence with command below the first level");

    a_completed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_completed |=> r_completed)
        else $error("completion latch cleared without reset");

    a_commit_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> ($past(r_state) == S_CALC && !$past(div_busy)))
        else $error("result issued while the divider was busy");
`endif

endmodule

`default_nettype wire

### design/mst_step_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mst_step_div
    import mst_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEFAULT,
    parameter int QUOT_W     = $clog2(STEP_COUNT + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [TIME_W-1:0]   i_dividend,
    input  wire logic [PERIOD_W-1:0] i_divisor,
    output logic                     o_busy,
    output logic [QUOT_W-1:0]        o_quot
);

    // Repeated subtraction with one shared subtractor. The quotient stops at
    // STEP_COUNT, which stands for any step at or past the end of the run.
    localparam logic [QUOT_W-1:0] QUOT_LIMIT = QUOT_W'(STEP_COUNT);

    logic              r_busy, n_busy;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic [PERIOD_W-1:0] r_div, n_div;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [TIME_W-1:0] div_ext;
    logic              can_sub;

    always_comb begin
        div_ext = TIME_W'(r_div);
        can_sub = (r_rem >= div_ext) && (r_quot != QUOT_LIMIT);
        n_busy  = r_busy;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quot  = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_rem  = i_dividend;
            n_div  = i_divisor;
            n_quot = '0;
        end else if (r_busy) begin
            if (can_sub) begin
                n_rem  = r_rem - div_ext;
                n_quot = r_quot + QUOT_W'(1);
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_quot <= '0;
        end else begin
            r_busy <= n_busy;
            r_quot <= n_quot;
        end
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire
